@@ hw/rtl/gji_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gji_pkg
// Shared types and constants of the Gauss-Jordan inverter: the inner
// fixed-point limits and the command and status words between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package gji_pkg;

    // Inner word width and the width of the stream value.
    localparam int INNER_W = 48;
    localparam int Q_W     = 32;

    // Row and column counters hold the matrix order itself.
    localparam int CNT_W = 4;

    // Inner saturation limits and the magnitude of the negative limit.
    localparam logic signed [INNER_W-1:0] POS_LIM = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [INNER_W-1:0] NEG_LIM = 48'sh8000_0000_0000;
    localparam logic [INNER_W:0]          MAG_POS = 49'h0_7FFF_FFFF_FFFF;
    localparam logic [INNER_W:0]          MAG_NEG = 49'h0_8000_0000_0000;

    // Store selector.
    localparam logic SEL_WORK = 1'b0;
    localparam logic SEL_INV  = 1'b1;

    // Datapath operations.
    typedef enum logic [2:0] {
        OP_PIVOT = 3'd0,
        OP_FLOAD = 3'd1,
        OP_SCALE = 3'd2,
        OP_ELIM  = 3'd3,
        OP_OUT   = 3'd4
    } gji_op_t;

    typedef struct packed {
        logic             start;
        gji_op_t          op;
        logic             sel;
        logic [CNT_W-1:0] row_a;
        logic [CNT_W-1:0] row_b;
        logic [CNT_W-1:0] col;
        logic             load_we;
        logic             zero_out;
    } gji_cmd_t;

    typedef struct packed {
        logic done;
        logic piv_zero;
    } gji_status_t;

endpackage

@@ hw/rtl/gji_recip.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gji_recip
// Restoring divider that forms the rounded reciprocal 2^(2F) / pivot, one
// quotient bit per cycle, saturated to the inner range.
// ----------------------------------------------------------------------------
module gji_recip #(
    parameter int INNER_FRAC_BITS = 24
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              start,
    input  logic [gji_pkg::INNER_W-1:0]       divisor,
    input  logic                              neg,
    output logic                              done,
    output logic signed [gji_pkg::INNER_W-1:0] recip
);
    import gji_pkg::*;

    localparam int ITER = 2 * INNER_FRAC_BITS + 1;
    localparam int CW   = $clog2(ITER + 1);

    typedef enum logic [3:0] {
        R_IDLE = 4'b0001,
        R_RUN  = 4'b0010,
        R_RND  = 4'b0100,
        R_FIN  = 4'b1000
    } rstate_t;

    rstate_t                    state_reg;
    logic [CW-1:0]              cnt_reg;
    logic [INNER_W:0]           rem_reg;
    logic [INNER_W:0]           q_reg;
    logic                       big_reg;
    logic [INNER_W-1:0]         d_reg;
    logic                       neg_reg;
    logic                       done_reg;
    logic signed [INNER_W-1:0]  recip_reg;

    logic [INNER_W:0] rem_sh;
    logic             ge;
    logic [INNER_W:0] q_sh;
    logic [INNER_W:0] rem_diff;

    // One step of the restoring division; the dividend has a single set bit.
    always_comb begin
        rem_sh   = {rem_reg[INNER_W-1:0], (cnt_reg == '0)};
        ge       = (rem_sh >= {1'b0, d_reg});
        q_sh     = {q_reg[INNER_W-1:0], ge};
        rem_diff = {1'b0, d_reg} - rem_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= R_IDLE;
            done_reg  <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            case (state_reg)
                R_IDLE: begin
                    if (start) begin
                        d_reg     <= divisor;
                        neg_reg   <= neg;
                        rem_reg   <= '0;
                        q_reg     <= '0;
                        big_reg   <= 1'b0;
                        cnt_reg   <= '0;
                        state_reg <= R_RUN;
                    end
                end
                R_RUN: begin
                    rem_reg <= ge ? (rem_sh - {1'b0, d_reg}) : rem_sh;
                    if (!big_reg) begin
                        q_reg   <= q_sh;
                        big_reg <= (q_sh > MAG_NEG);
                    end
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CW'(ITER - 1)) begin
                        state_reg <= R_RND;
                    end
                end
                R_RND: begin
                    // Round to nearest, ties away from zero.
                    if (!big_reg && (rem_reg >= rem_diff)) begin
                        q_reg <= q_reg + 1'b1;
                    end
                    state_reg <= R_FIN;
                end
                R_FIN: begin
                    if (neg_reg) begin
                        recip_reg <= (big_reg || q_reg >= MAG_NEG) ? NEG_LIM :
                                     -$signed(q_reg[INNER_W-1:0]);
                    end else begin
                        recip_reg <= (big_reg || q_reg > MAG_POS) ? POS_LIM :
                                     $signed(q_reg[INNER_W-1:0]);
                    end
                    done_reg  <= 1'b1;
                    state_reg <= R_IDLE;
                end
                default: begin
                    state_reg <= R_IDLE;
                end
            endcase
        end
    end

    assign done  = done_reg;
    assign recip = recip_reg;

endmodule

@@ hw/rtl/gji_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gji_dp
// Datapath: the work and companion stores, a shared 24x24 multiplier that
// forms each product in four passes, the reciprocal unit and the output
// rounding to Q16.16.
// ----------------------------------------------------------------------------
module gji_dp #(
    parameter int MAX_SIZE        = 8,
    parameter int INNER_FRAC_BITS = 24
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  gji_pkg::gji_cmd_t             cmd,
    output gji_pkg::gji_status_t          status,
    input  logic signed [gji_pkg::Q_W-1:0] elem_value,
    output logic signed [gji_pkg::Q_W-1:0] inv_value,
    output logic                          inv_sat
);
    import gji_pkg::*;

    localparam int IW    = $clog2(MAX_SIZE);
    localparam int AW    = 2 * IW;
    localparam int DEPTH = 1 << AW;
    localparam int S     = INNER_FRAC_BITS - 16;
    localparam logic [INNER_W:0] RND_O =
        (S > 0) ? (49'd1 << ((S > 0) ? (S - 1) : 0)) : 49'd0;
    localparam logic [96:0] RND_M = 97'd1 << (INNER_FRAC_BITS - 1);
    localparam logic signed [INNER_W-1:0] ONE = 48'sd1 <<< INNER_FRAC_BITS;

    function automatic logic [INNER_W-1:0] mag(input logic signed [INNER_W-1:0] v);
        return v[INNER_W-1] ? INNER_W'(-v) : INNER_W'(v);
    endfunction

    logic signed [INNER_W-1:0] wmem [DEPTH];
    logic signed [INNER_W-1:0] imem [DEPTH];

    logic signed [INNER_W-1:0] wa_reg, wb_reg, ia_reg, ib_reg;
    logic signed [INNER_W-1:0] f_reg, b_reg, res_reg;
    logic [INNER_W-1:0]        ma_reg, mb_reg;
    logic                      neg_reg;
    logic [95:0]               acc_reg;
    logic [INNER_W:0]          t_reg;
    logic                      tbig_reg;
    logic [3:0]                ph_reg;
    logic                      done_reg, pz_reg;
    logic                      rstart_reg;
    logic [INNER_W:0]          om_reg;
    logic                      oneg_reg, oclip_reg;
    logic signed [Q_W-1:0]     out_val_reg;
    logic                      out_sat_reg;

    logic [AW-1:0]             addr_a, addr_b;
    logic signed [INNER_W-1:0] a_val, b_val, bop, elem_ext;
    logic [1:0]                pass;
    logic [23:0]               ah, bh;
    logic [47:0]               prod;
    logic [95:0]               prod_sh;
    logic [96:0]               t_full;
    logic signed [INNER_W:0]   diff;
    logic signed [INNER_W-1:0] diff_sat;
    logic                      rdone;
    logic signed [INNER_W-1:0] rcp;

    // Addresses and operand selection.
    always_comb begin
        addr_a   = {cmd.row_a[IW-1:0], cmd.col[IW-1:0]};
        addr_b   = {cmd.row_b[IW-1:0], cmd.col[IW-1:0]};
        a_val    = (cmd.sel == SEL_INV) ? ia_reg : wa_reg;
        b_val    = (cmd.sel == SEL_INV) ? ib_reg : wb_reg;
        bop      = (cmd.op == OP_SCALE) ? rcp : f_reg;
        elem_ext = INNER_W'(elem_value) <<< S;
    end

    // One partial product per pass, placed by the halves it uses.
    always_comb begin
        pass = 2'(ph_reg - 4'd2);
        ah   = pass[0] ? ma_reg[47:24] : ma_reg[23:0];
        bh   = pass[1] ? mb_reg[47:24] : mb_reg[23:0];
        prod = ah * bh;
        case (2'(pass[0]) + 2'(pass[1]))
            2'd0:    prod_sh = {48'd0, prod};
            2'd1:    prod_sh = {24'd0, prod, 24'd0};
            default: prod_sh = {prod, 48'd0};
        endcase
        t_full = ({1'b0, acc_reg} + RND_M) >> INNER_FRAC_BITS;
    end

    // Saturating subtraction for elimination.
    always_comb begin
        diff = {b_reg[INNER_W-1], b_reg} - {res_reg[INNER_W-1], res_reg};
        if (diff > $signed({1'b0, POS_LIM})) begin
            diff_sat = POS_LIM;
        end else if (diff < $signed({1'b1, NEG_LIM})) begin
            diff_sat = NEG_LIM;
        end else begin
            diff_sat = diff[INNER_W-1:0];
        end
    end

    // Store writes and registered reads.
    always_ff @(posedge aclk) begin
        if (cmd.load_we) begin
            wmem[addr_a] <= elem_ext;
            imem[addr_a] <= (cmd.row_a == cmd.col) ? ONE : '0;
        end else if (ph_reg == 4'd8) begin
            if (cmd.sel == SEL_INV) begin
                imem[(cmd.op == OP_ELIM) ? addr_b : addr_a] <=
                    (cmd.op == OP_ELIM) ? diff_sat : res_reg;
            end else begin
                wmem[(cmd.op == OP_ELIM) ? addr_b : addr_a] <=
                    (cmd.op == OP_ELIM) ? diff_sat : res_reg;
            end
        end
        if (cmd.start) begin
            wa_reg <= wmem[addr_a];
            wb_reg <= wmem[addr_b];
            ia_reg <= imem[addr_a];
            ib_reg <= imem[addr_b];
        end
    end

    // Operation sequencer: phase 1 sees the read data.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ph_reg     <= '0;
            done_reg   <= 1'b0;
            pz_reg     <= 1'b0;
            rstart_reg <= 1'b0;
        end else begin
            done_reg   <= 1'b0;
            rstart_reg <= 1'b0;
            if (cmd.start) begin
                ph_reg <= 4'd1;
            end else if (ph_reg != '0) begin
                case (cmd.op)
                    OP_PIVOT: begin
                        if (ph_reg == 4'd1) begin
                            // The divisor magnitude and sign reuse the multiplier
                            // operand registers, since no product is in flight.
                            ma_reg  <= mag(a_val);
                            neg_reg <= a_val[INNER_W-1];
                            pz_reg  <= (a_val == '0);
                            if (a_val == '0) begin
                                ph_reg   <= '0;
                                done_reg <= 1'b1;
                            end else begin
                                rstart_reg <= 1'b1;
                                ph_reg     <= 4'd2;
                            end
                        end else if (rdone) begin
                            ph_reg   <= '0;
                            done_reg <= 1'b1;
                        end
                    end
                    OP_FLOAD: begin
                        f_reg    <= a_val;
                        ph_reg   <= '0;
                        done_reg <= 1'b1;
                    end
                    OP_OUT: begin
                        if (ph_reg == 4'd1) begin
                            oneg_reg  <= a_val[INNER_W-1];
                            oclip_reg <= (a_val == POS_LIM) || (a_val == NEG_LIM);
                            om_reg    <= ({1'b0, mag(a_val)} + RND_O) >> S;
                            ph_reg    <= 4'd2;
                        end else begin
                            if (cmd.zero_out) begin
                                out_val_reg <= '0;
                                out_sat_reg <= 1'b0;
                            end else if (!oneg_reg && om_reg > 49'h0_7FFF_FFFF) begin
                                out_val_reg <= 32'sh7FFF_FFFF;
                                out_sat_reg <= 1'b1;
                            end else if (oneg_reg && om_reg > 49'h0_8000_0000) begin
                                out_val_reg <= 32'sh8000_0000;
                                out_sat_reg <= 1'b1;
                            end else begin
                                out_val_reg <= oneg_reg ? -$signed(om_reg[Q_W-1:0]) :
                                                          $signed(om_reg[Q_W-1:0]);
                                out_sat_reg <= oclip_reg;
                            end
                            ph_reg   <= '0;
                            done_reg <= 1'b1;
                        end
                    end
                    default: begin
                        // Scale and eliminate share the multiply phases.
                        case (ph_reg)
                            4'd1: begin
                                ma_reg  <= mag(a_val);
                                mb_reg  <= mag(bop);
                                neg_reg <= a_val[INNER_W-1] ^ bop[INNER_W-1];
                                b_reg   <= b_val;
                                acc_reg <= '0;
                            end
                            4'd2, 4'd3, 4'd4, 4'd5: begin
                                acc_reg <= acc_reg + prod_sh;
                            end
                            4'd6: begin
                                t_reg    <= t_full[INNER_W:0];
                                tbig_reg <= |t_full[96:INNER_W+1];
                            end
                            4'd7: begin
                                if (neg_reg) begin
                                    res_reg <= (tbig_reg || t_reg >= MAG_NEG) ? NEG_LIM :
                                               -$signed(t_reg[INNER_W-1:0]);
                                end else begin
                                    res_reg <= (tbig_reg || t_reg > MAG_POS) ? POS_LIM :
                                               $signed(t_reg[INNER_W-1:0]);
                                end
                            end
                            default: begin
                                done_reg <= 1'b1;
                            end
                        endcase
                        ph_reg <= (ph_reg == 4'd8) ? 4'd0 : ph_reg + 4'd1;
                    end
                endcase
            end
        end
    end

    gji_recip #(
        .INNER_FRAC_BITS(INNER_FRAC_BITS)
    ) u_recip (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (rstart_reg),
        .divisor (ma_reg),
        .neg     (neg_reg),
        .done    (rdone),
        .recip   (rcp)
    );

    assign status.done     = done_reg;
    assign status.piv_zero = pz_reg;
    assign inv_value       = out_val_reg;
    assign inv_sat         = out_sat_reg;

endmodule

@@ hw/rtl/gji_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gji_ctrl
// Controller: loads the matrix, walks pivots, rows and columns of the
// elimination and sequences the output words.
// ----------------------------------------------------------------------------
module gji_ctrl #(
    parameter int MAX_SIZE = 8
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_wr_en,
    input  logic [gji_pkg::CNT_W-1:0]   cfg_wr_data,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic                        m_last,
    output logic                        m_singular,
    output gji_pkg::gji_cmd_t           cmd,
    input  gji_pkg::gji_status_t        status
);
    import gji_pkg::*;

    typedef enum logic [6:0] {
        ST_LOAD  = 7'b0000001,
        ST_PIV   = 7'b0000010,
        ST_SCALE = 7'b0000100,
        ST_FRD   = 7'b0001000,
        ST_ELIM  = 7'b0010000,
        ST_ORD   = 7'b0100000,
        ST_OHOLD = 7'b1000000
    } state_t;

    state_t           state_reg;
    logic [CNT_W-1:0] size_reg;
    logic [CNT_W-1:0] row_reg, col_reg, i_reg, j_reg, k_reg;
    logic             sel_reg;
    logic             go_reg;
    logic             m_tvalid_reg, m_last_reg, sing_reg;

    logic [CNT_W-1:0] n, n_m1, k_first, k_inc, k_next;
    logic             last_cell;

    // Effective order and loop bounds.
    always_comb begin
        if (size_reg == '0) begin
            n = CNT_W'(1);
        end else if (size_reg > CNT_W'(MAX_SIZE)) begin
            n = CNT_W'(MAX_SIZE);
        end else begin
            n = size_reg;
        end
        n_m1      = n - 1'b1;
        k_first   = (i_reg == '0) ? CNT_W'(1) : '0;
        k_inc     = k_reg + 1'b1;
        k_next    = (k_inc == i_reg) ? k_inc + 1'b1 : k_inc;
        last_cell = (row_reg == n_m1) && (col_reg == n_m1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_LOAD;
            size_reg     <= CNT_W'(8);
            row_reg      <= '0;
            col_reg      <= '0;
            i_reg        <= '0;
            j_reg        <= '0;
            k_reg        <= '0;
            sel_reg      <= SEL_WORK;
            go_reg       <= 1'b0;
            m_tvalid_reg <= 1'b0;
            m_last_reg   <= 1'b0;
            sing_reg     <= 1'b0;
        end else begin
            go_reg <= 1'b0;
            if (cfg_wr_en) begin
                size_reg <= cfg_wr_data;
                row_reg  <= '0;
                col_reg  <= '0;
            end
            case (state_reg)
                ST_LOAD: begin
                    if (s_tvalid && !cfg_wr_en) begin
                        if (last_cell) begin
                            row_reg   <= '0;
                            col_reg   <= '0;
                            i_reg     <= '0;
                            sing_reg  <= 1'b0;
                            go_reg    <= 1'b1;
                            state_reg <= ST_PIV;
                        end else if (col_reg == n_m1) begin
                            col_reg <= '0;
                            row_reg <= row_reg + 1'b1;
                        end else begin
                            col_reg <= col_reg + 1'b1;
                        end
                    end
                end
                ST_PIV: begin
                    if (status.done) begin
                        go_reg <= 1'b1;
                        if (status.piv_zero) begin
                            sing_reg  <= 1'b1;
                            state_reg <= ST_ORD;
                        end else begin
                            j_reg     <= '0;
                            sel_reg   <= SEL_WORK;
                            state_reg <= ST_SCALE;
                        end
                    end
                end
                ST_SCALE, ST_ELIM: begin
                    // Each column is done for the work row, then the companion row.
                    if (status.done) begin
                        go_reg <= 1'b1;
                        if (sel_reg == SEL_WORK) begin
                            sel_reg <= SEL_INV;
                        end else begin
                            sel_reg <= SEL_WORK;
                            if (j_reg != n_m1) begin
                                j_reg <= j_reg + 1'b1;
                            end else begin
                                j_reg <= '0;
                                if (state_reg == ST_SCALE && k_first < n) begin
                                    k_reg     <= k_first;
                                    state_reg <= ST_FRD;
                                end else if (state_reg == ST_ELIM && k_next < n) begin
                                    k_reg     <= k_next;
                                    state_reg <= ST_FRD;
                                end else if (i_reg == n_m1) begin
                                    state_reg <= ST_ORD;
                                end else begin
                                    i_reg     <= i_reg + 1'b1;
                                    state_reg <= ST_PIV;
                                end
                            end
                        end
                    end
                end
                ST_FRD: begin
                    if (status.done) begin
                        j_reg     <= '0;
                        sel_reg   <= SEL_WORK;
                        go_reg    <= 1'b1;
                        state_reg <= ST_ELIM;
                    end
                end
                ST_ORD: begin
                    if (status.done) begin
                        m_tvalid_reg <= 1'b1;
                        m_last_reg   <= last_cell;
                        state_reg    <= ST_OHOLD;
                    end
                end
                ST_OHOLD: begin
                    if (m_tready) begin
                        m_tvalid_reg <= 1'b0;
                        if (m_last_reg) begin
                            row_reg   <= '0;
                            col_reg   <= '0;
                            state_reg <= ST_LOAD;
                        end else begin
                            if (col_reg == n_m1) begin
                                col_reg <= '0;
                                row_reg <= row_reg + 1'b1;
                            end else begin
                                col_reg <= col_reg + 1'b1;
                            end
                            go_reg    <= 1'b1;
                            state_reg <= ST_ORD;
                        end
                    end
                end
                default: begin
                    state_reg <= ST_LOAD;
                end
            endcase
        end
    end

    // Command word for the datapath.
    always_comb begin
        cmd.start    = go_reg;
        cmd.op       = OP_OUT;
        cmd.sel      = sel_reg;
        cmd.row_a    = i_reg;
        cmd.row_b    = k_reg;
        cmd.col      = j_reg;
        cmd.load_we  = 1'b0;
        cmd.zero_out = sing_reg;
        case (state_reg)
            ST_LOAD: begin
                cmd.row_a   = row_reg;
                cmd.col     = col_reg;
                cmd.load_we = s_tvalid && !cfg_wr_en;
            end
            ST_PIV: begin
                cmd.op  = OP_PIVOT;
                cmd.sel = SEL_WORK;
                cmd.col = i_reg;
            end
            ST_FRD: begin
                cmd.op    = OP_FLOAD;
                cmd.sel   = SEL_WORK;
                cmd.row_a = k_reg;
                cmd.col   = i_reg;
            end
            ST_SCALE: begin
                cmd.op = OP_SCALE;
            end
            ST_ELIM: begin
                cmd.op = OP_ELIM;
            end
            default: begin
                cmd.sel   = SEL_INV;
                cmd.row_a = row_reg;
                cmd.col   = col_reg;
            end
        endcase
    end

    assign s_tready   = (state_reg == ST_LOAD) && !cfg_wr_en;
    assign m_tvalid   = m_tvalid_reg;
    assign m_last     = m_last_reg;
    assign m_singular = sing_reg;

`ifndef SYNTHESIS
    // Loading and output never overlap.
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid_reg))
        else $error("input ready while a result word is pending");

    // No datapath operation is launched while a result word waits.
    a_no_start_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !(go_reg && m_tvalid_reg))
        else $error("datapath started during output hold");

    // After the last word of the inverse the block is ready for a new matrix.
    a_back_to_load: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && m_tready && m_last_reg) |=> (state_reg == ST_LOAD))
        else $error("no return to loading after the last word");
`endif

endmodule

@@ hw/rtl/gauss_jordan_matrix_inverse.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gauss_jordan_matrix_inverse
// Streaming Gauss-Jordan inverter for a square Q16.16 matrix of up to
// MAX_SIZE rows, without row exchange, with singular and saturation flags.
//
//   Channel   Dir  Signals                     Contents
//   s_        in   tvalid tready tdata[31:0]   elem_value, row-major
//   m_        out  tvalid tready tdata[31:0]   inv_value, row-major
//                  tlast tuser[1:0]            is_last; singular, saturated
//   cfg_      in   wr_en wr_data[3:0]          matrix_size
//
// Loading accepts one element per cycle, except in a cycle with a size write.
// Elimination runs every product through one 24x24 multiplier in four passes,
// and each nonzero pivot waits on the bit-serial reciprocal. Each output word
// is formed only after the previous one is taken, so it waits on any stall on
// m_tready; no input is taken until the last word is delivered.
// Reset is synchronous; the stores need no clearing pass.
// ----------------------------------------------------------------------------
module gauss_jordan_matrix_inverse #(
    parameter int MAX_SIZE        = 8,
    parameter int INNER_FRAC_BITS = 24
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [3:0]  cfg_wr_data,    // matrix_size
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,        // [31:0] elem_value
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,        // [31:0] inv_value
    output logic        m_tlast,
    output logic [1:0]  m_tuser         // [0] singular, [1] saturated
);
    import gji_pkg::*;

    gji_cmd_t              cmd;
    gji_status_t           status;
    logic signed [Q_W-1:0] inv_value;
    logic                  inv_sat;
    logic                  singular;

    gji_ctrl #(
        .MAX_SIZE(MAX_SIZE)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_last     (m_tlast),
        .m_singular (singular),
        .cmd        (cmd),
        .status     (status)
    );

    gji_dp #(
        .MAX_SIZE       (MAX_SIZE),
        .INNER_FRAC_BITS(INNER_FRAC_BITS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .elem_value($signed(s_tdata)),
        .inv_value (inv_value),
        .inv_sat   (inv_sat)
    );

    assign m_tdata = inv_value;
    assign m_tuser = {inv_sat, singular};

endmodule

@@ verif/gauss_jordan_matrix_inverse_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gauss_jordan_matrix_inverse_test
// Self-checking bench for the streaming Gauss-Jordan inverter. Matrices go in
// one element per word; a bit-accurate inversion model predicts every inverse
// word, which is checked field by field. Directed cases cover the element
// extremes, zero pivots, size coding and dropped loads; the random part runs
// mostly well-conditioned matrices, with noise, singular and tiny matrices
// mixed in, under random stalls on both streams.
// ----------------------------------------------------------------------------
module gauss_jordan_matrix_inverse_test;
    import gji_pkg::*;

    localparam int  FRAC      = 24;
    localparam int  MAXN      = 8;
    localparam int  WD_LIMIT  = 200000;
    localparam int  RAND_WORDS = 430;
    localparam longint ONE_INNER = longint'(1) << FRAC;

    typedef struct {
        logic [31:0] inv_value;
        logic        is_last;
        logic        singular;
        logic        saturated;
    } inv_word_t;

    typedef enum int {MX_WELL, MX_NOISE, MX_ZERO_ROW, MX_TINY} mx_kind_t;

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [3:0]  cfg_wr_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic        m_tlast;
    logic [1:0]  m_tuser;

    inv_word_t   inverse_q[$];
    longint      work_m[MAXN*MAXN];
    longint      inv_m[MAXN*MAXN];
    logic [3:0]  size_reg;
    int          loaded;
    int          errors;
    int          words_sent;
    int          ready_hold;
    int          quiet_cycles;
    bit          calm;

    gauss_jordan_matrix_inverse DUT (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .m_tuser    (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Fixed-point arithmetic of the inner format.
    // ------------------------------------------------------------------
    function automatic logic [63:0] mag_of(longint v);
        return (v < 0) ? 64'(-v) : 64'(v);
    endfunction

    function automatic longint clip_signed(bit neg, logic [127:0] m);
        if (neg) begin
            return (m >= 128'(MAG_NEG)) ? longint'(NEG_LIM) : -longint'(m[63:0]);
        end
        return (m > 128'(MAG_POS)) ? longint'(POS_LIM) : longint'(m[63:0]);
    endfunction

    function automatic longint fx_product(longint a, longint b);
        logic [127:0] p;
        p = 128'(mag_of(a)) * 128'(mag_of(b));
        p = (p + (128'd1 << (FRAC - 1))) >> FRAC;
        return clip_signed((a < 0) != (b < 0), p);
    endfunction

    function automatic longint fx_diff(longint a, longint b);
        longint d;
        d = a - b;
        if (d > longint'(POS_LIM)) return longint'(POS_LIM);
        if (d < longint'(NEG_LIM)) return longint'(NEG_LIM);
        return d;
    endfunction

    function automatic longint fx_reciprocal(longint p);
        logic [127:0] d, q, r;
        d = 128'(mag_of(p));
        q = (128'd1 << (2 * FRAC)) / d;
        r = (128'd1 << (2 * FRAC)) % d;
        if (q > 128'(MAG_NEG)) return (p < 0) ? longint'(NEG_LIM) : longint'(POS_LIM);
        if (2 * r >= d) q = q + 1;
        return clip_signed(p < 0, q);
    endfunction

    // Inner value to Q16.16 with round-half-away and clipping.
    function automatic inv_word_t to_stream(longint v);
        inv_word_t   w;
        logic [63:0] m;
        bit          neg;
        neg = v < 0;
        m = mag_of(v);
        w.saturated = (v == longint'(POS_LIM)) || (v == longint'(NEG_LIM));
        m = (m + (64'd1 << (FRAC - 17))) >> (FRAC - 16);
        if (!neg && m > 64'h7FFF_FFFF) begin
            m = 64'h7FFF_FFFF;
            w.saturated = 1'b1;
        end
        if (neg && m > 64'h8000_0000) begin
            m = 64'h8000_0000;
            w.saturated = 1'b1;
        end
        w.inv_value = neg ? 32'(-m) : m[31:0];
        w.singular  = 1'b0;
        w.is_last   = 1'b0;
        return w;
    endfunction

    function automatic int order_in_use();
        if (size_reg == 0) return 1;
        if (size_reg > MAXN) return MAXN;
        return int'(size_reg);
    endfunction

    // Eliminate in place; returns 1 when a zero pivot stops the run.
    function automatic bit eliminate(int n);
        longint piv, rcp, f;
        for (int i = 0; i < n; i++)
            for (int j = 0; j < n; j++)
                inv_m[i*n+j] = (i == j) ? ONE_INNER : 0;
        for (int i = 0; i < n; i++) begin
            piv = work_m[i*n+i];
            if (piv == 0) return 1'b1;
            rcp = fx_reciprocal(piv);
            for (int j = 0; j < n; j++) begin
                inv_m[i*n+j]  = fx_product(inv_m[i*n+j], rcp);
                work_m[i*n+j] = fx_product(work_m[i*n+j], rcp);
            end
            for (int k = 0; k < n; k++) begin
                if (k != i) begin
                    f = work_m[k*n+i];
                    for (int j = 0; j < n; j++) begin
                        work_m[k*n+j] = fx_diff(work_m[k*n+j], fx_product(f, work_m[i*n+j]));
                        inv_m[k*n+j]  = fx_diff(inv_m[k*n+j], fx_product(f, inv_m[i*n+j]));
                    end
                end
            end
        end
        return 1'b0;
    endfunction

    // Takes one accepted element; on the last one queues the whole inverse.
    function automatic void take_element(logic [31:0] v);
        int        n, cells;
        bit        sing;
        inv_word_t w;
        n = order_in_use();
        cells = n * n;
        if (loaded >= cells) loaded = 0;
        work_m[loaded] = longint'($signed(v)) * 256;
        loaded++;
        if (loaded < cells) return;
        loaded = 0;
        sing = eliminate(n);
        for (int c = 0; c < cells; c++) begin
            if (sing) begin
                w.inv_value = '0;
                w.saturated = 1'b0;
            end else begin
                w = to_stream(inv_m[c]);
            end
            w.singular = sing;
            w.is_last  = (c == cells - 1);
            inverse_q.push_back(w);
        end
    endfunction

    function automatic int idle_draw();
        return calm ? 0 : $urandom_range(0, 4);
    endfunction

    // ------------------------------------------------------------------
    // Stream drivers. All inputs change at the falling edge.
    // ------------------------------------------------------------------
    task automatic send_element(logic [31:0] v);
        int gap;
        gap = idle_draw();
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = v;
        do @(posedge aclk); while (!s_tready);
        take_element(v);
        words_sent++;
        @(negedge aclk);
    endtask

    task automatic wait_drained();
        s_tvalid = 1'b0;
        wait (inverse_q.size() == 0);
        repeat (8) @(negedge aclk);
    endtask

    task automatic write_size(logic [3:0] value);
        wait_drained();
        cfg_wr_en   = 1'b1;
        cfg_wr_data = value;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
        size_reg  = value;
        loaded    = 0;
    endtask

    function automatic logic [31:0] make_element(mx_kind_t kind, int i, int j, int zrow);
        logic [31:0] v;
        case (kind)
            MX_NOISE: v = $urandom;
            MX_TINY:  v = 32'($urandom_range(0, 6)) - 32'd3;
            default: begin
                if (kind == MX_ZERO_ROW && i == zrow) begin
                    v = '0;
                end else if (i == j) begin
                    v = 32'($urandom_range(32'h2_0000, 32'h8_0000));
                    if ($urandom_range(0, 1)) v = -v;
                end else begin
                    v = 32'($urandom_range(0, 32'h1_FFFF)) - 32'h1_0000;
                end
            end
        endcase
        return v;
    endfunction

    task automatic send_matrix(mx_kind_t kind, int stop_after);
        int n, zrow, sent;
        n = order_in_use();
        zrow = $urandom_range(0, n - 1);
        sent = 0;
        for (int i = 0; i < n; i++)
            for (int j = 0; j < n; j++)
                if (sent < stop_after) begin
                    send_element(make_element(kind, i, j, zrow));
                    sent++;
                end
        s_tvalid = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Result side: random back-pressure and the checker.
    // ------------------------------------------------------------------
    always @(negedge aclk) begin
        if (ready_hold > 0) begin
            m_tready <= 1'b0;
            ready_hold <= ready_hold - 1;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        inv_word_t w;
        if (aresetn && m_tvalid && m_tready) begin
            ready_hold = idle_draw();
            if (inverse_q.size() == 0) begin
                $error("unexpected inverse word %h", m_tdata);
                errors++;
            end else begin
                w = inverse_q.pop_front();
                if (m_tdata !== w.inv_value) begin
                    $error("inv_value: expected %h, got %h", w.inv_value, m_tdata);
                    errors++;
                end
                if (m_tlast !== w.is_last) begin
                    $error("is_last: expected %b, got %b", w.is_last, m_tlast);
                    errors++;
                end
                if (m_tuser[0] !== w.singular) begin
                    $error("singular: expected %b, got %b", w.singular, m_tuser[0]);
                    errors++;
                end
                if (m_tuser[1] !== w.saturated) begin
                    $error("saturated: expected %b, got %b", w.saturated, m_tuser[1]);
                    errors++;
                end
            end
        end
    end

    // Watchdog on cycles in which neither stream moves a word.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles > WD_LIMIT) begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------
    task automatic test_reset_size();
        calm = 1'b1;
        send_matrix(MX_WELL, 64);
        calm = 1'b0;
    endtask

    task automatic test_order_one_extremes();
        write_size(4'd1);
        send_element(32'h0000_0000);
        send_element(32'h0001_0000);
        send_element(32'hFFFF_0000);
        send_element(32'h7FFF_FFFF);
        send_element(32'h8000_0000);
        send_element(32'h0000_0001);
        send_element(32'hFFFF_FFFF);
        send_element(32'h0000_8000);
        s_tvalid = 1'b0;
    endtask

    task automatic test_pivot_cases();
        write_size(4'd2);
        // Identity, then a matrix whose second pivot cancels to zero.
        send_element(32'h0001_0000);
        send_element(32'h0000_0000);
        send_element(32'h0000_0000);
        send_element(32'h0001_0000);
        send_element(32'h0001_0000);
        send_element(32'h0001_0000);
        send_element(32'h0001_0000);
        send_element(32'h0001_0000);
        s_tvalid = 1'b0;
    endtask

    task automatic test_size_coding();
        // Zero acts as order one; values above the maximum act as eight.
        write_size(4'd0);
        send_element(32'h0002_0000);
        s_tvalid = 1'b0;
        write_size(4'd15);
        send_matrix(MX_WELL, 64);
    endtask

    task automatic test_dropped_load();
        // A write in the middle of a load throws the partial matrix away.
        write_size(4'd3);
        send_matrix(MX_WELL, 5);
        write_size(4'd2);
        send_matrix(MX_NOISE, 4);
    endtask

    task automatic test_random_matrices();
        int       pick, n;
        mx_kind_t kind;
        while (words_sent < RAND_WORDS) begin
            pick = $urandom_range(0, 19);
            if (pick == 0)       write_size(4'd8);
            else if (pick == 1)  write_size(4'($urandom_range(9, 15)));
            else if (pick == 2)  write_size(4'd0);
            else                 write_size(4'($urandom_range(1, 4)));
            n = order_in_use();
            if (n == MAXN && words_sent > RAND_WORDS - 90) n = 0;
            repeat ((n == 0) ? 0 : (n == MAXN) ? 1 : $urandom_range(1, 3)) begin
                calm = ($urandom_range(0, 3) == 0);
                pick = $urandom_range(0, 19);
                if (pick < 13)       kind = MX_WELL;
                else if (pick < 16)  kind = MX_NOISE;
                else if (pick < 18)  kind = MX_ZERO_ROW;
                else                 kind = MX_TINY;
                if ($urandom_range(0, 15) == 0)
                    send_matrix(kind, $urandom_range(1, order_in_use() * order_in_use()));
                else
                    send_matrix(kind, 64);
            end
        end
        calm = 1'b0;
    endtask

    initial begin
        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        m_tready    = 1'b0;
        size_reg    = 4'd8;
        loaded      = 0;
        errors      = 0;
        words_sent  = 0;
        ready_hold  = 0;
        quiet_cycles = 0;
        calm        = 1'b0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        test_reset_size();
        test_order_one_extremes();
        test_pivot_cases();
        test_size_coding();
        test_dropped_load();
        test_random_matrices();

        wait_drained();
        repeat (50) @(negedge aclk);
        if (errors == 0 && inverse_q.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
